/* design/assert_macros.svh */
// Assertion macros used by the record parser RTL.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define LPRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define LPRP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/lprp_pkg.sv */
// Shared types and constants for the length-prefixed record parser.
// No dependencies.
package lprp_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 65536;
  localparam int unsigned FRAME_W         = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned STR_W           = 17;

  localparam logic [31:0]      START_MARKER_RST = 32'h0000_008E;
  localparam logic [31:0]      END_MARKER_RST   = 32'h0000_008F;
  localparam logic [STR_W-1:0] STRING_LIMIT_RST = 17'h1_0000;

  localparam logic [1:0] CFG_START_MARKER = 2'd0;
  localparam logic [1:0] CFG_END_MARKER   = 2'd1;
  localparam logic [1:0] CFG_STRING_LIMIT = 2'd2;

  localparam logic [31:0] ERR_NEG_FRAME   = 32'd1;
  localparam logic [31:0] ERR_BIG_FRAME   = 32'd2;
  localparam logic [31:0] ERR_BIG_STRING  = 32'd3;
  localparam logic [31:0] ERR_TRUNCATED   = 32'd4;

  typedef enum logic [2:0] {
    KIND_HOST   = 3'd0,
    KIND_USER   = 3'd1,
    KIND_CMD    = 3'd2,
    KIND_MSG    = 3'd3,
    KIND_DONE   = 3'd4,
    KIND_ERROR  = 3'd5,
    KIND_REJECT = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        string_end;
  } result_t;

  typedef struct packed {
    logic [31:0]      start_marker;
    logic [31:0]      end_marker;
    logic [STR_W-1:0] string_limit;
  } cfg_t;

endpackage

/* design/lprp_in_if.sv */
// Byte input channel of the record parser.
// No dependencies.
interface lprp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

/* design/lprp_out_if.sv */
// Result channel of the record parser.
// No dependencies.
interface lprp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] value;
  logic        string_end;

  modport source (output valid, output kind, output value, output string_end, input ready);
  modport sink   (input valid, input kind, input value, input string_end, output ready);
endinterface

/* design/length_prefixed_record_parser_top.sv */
// Top level of the length-prefixed record parser: configuration registers,
// front end and result queue. Depends on lprp_pkg, the channel interfaces,
// lprp_front, lprp_queue and assert_macros.svh.
//
// Takes one byte per clock while input ready is high: each transferred byte updates
// the frame and record state in the same cycle, and any result it causes reaches
// the result channel in the cycle after at the earliest, behind any results still
// waiting in the two-entry queue. Input ready drops only while both queue
// entries hold results the sink has not taken. After reset the block is ready
// at once; there is no clearing pass.
`include "assert_macros.svh"

module length_prefixed_record_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  lprp_in_if.sink     in_ch,
  lprp_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  lprp_pkg::cfg_t    cfg_r;
  logic              q_ready;
  logic              push_valid;
  lprp_pkg::result_t push_data;
  logic              sticky_err;
  logic              out_str_end;
  logic              out_str_kind;

  assign out_str_end  = out_ch.valid && out_ch.string_end;
  assign out_str_kind = (out_ch.kind == lprp_pkg::KIND_USER) ||
                        (out_ch.kind == lprp_pkg::KIND_MSG);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker <= lprp_pkg::START_MARKER_RST;
      cfg_r.end_marker   <= lprp_pkg::END_MARKER_RST;
      cfg_r.string_limit <= lprp_pkg::STRING_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lprp_pkg::CFG_START_MARKER: cfg_r.start_marker <= cfg_data;
        lprp_pkg::CFG_END_MARKER:   cfg_r.end_marker   <= cfg_data;
        lprp_pkg::CFG_STRING_LIMIT: cfg_r.string_limit <= cfg_data[lprp_pkg::STR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lprp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_ch      (in_ch),
    .q_ready    (q_ready),
    .push_valid (push_valid),
    .push_data  (push_data),
    .sticky_err (sticky_err)
  );

  lprp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (q_ready),
    .out_ch     (out_ch)
  );

  `LPRP_ASSERT(a_push_room, push_valid |-> q_ready, "result pushed into a full queue")
  `LPRP_ASSERT(a_sticky_silent, sticky_err |-> !push_valid, "result after sticky error")
  `LPRP_ASSERT(a_string_end_kind, out_str_end |-> out_str_kind, "string end on other kind")

endmodule

/* design/lprp_front.sv */
// Front end: frame splitting and record parsing, one byte per transfer.
// Depends on lprp_pkg and lprp_in_if; pushes results into lprp_queue.
module lprp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  lprp_pkg::cfg_t    cfg,
  lprp_in_if.sink           in_ch,
  input  logic              q_ready,
  output logic              push_valid,
  output lprp_pkg::result_t push_data,
  output logic              sticky_err
);

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_HOST    = 4'd1,
    PH_ULEN    = 4'd2,
    PH_UBYTES  = 4'd3,
    PH_CMD     = 4'd4,
    PH_MLEN    = 4'd5,
    PH_MBYTES  = 4'd6,
    PH_END     = 4'd7,
    PH_DISCARD = 4'd8
  } phase_t;

  function automatic logic is_word_phase(input phase_t p);
    return (p == PH_START) || (p == PH_HOST) || (p == PH_ULEN) ||
           (p == PH_CMD) || (p == PH_MLEN) || (p == PH_END);
  endfunction

  function automatic logic is_str_phase(input phase_t p);
    return (p == PH_UBYTES) || (p == PH_MBYTES);
  endfunction

  logic                          frame_on_r,  frame_on_nxt;
  logic [lprp_pkg::FRAME_W-1:0]  frame_rem_r, frame_rem_nxt;
  logic [23:0]                   shift_r,     shift_nxt;
  logic [1:0]                    cnt_r,       cnt_nxt;
  phase_t                        phase_r,     phase_nxt;
  logic [lprp_pkg::STR_W-1:0]    str_rem_r,   str_rem_nxt;
  logic                          had_zero_r,  had_zero_nxt;
  logic                          sticky_r,    sticky_nxt;

  logic                          accept;
  logic [7:0]                    b;
  logic [31:0]                   word;
  logic                          word_done;
  logic [lprp_pkg::FRAME_W-1:0]  rem_dec;
  logic [lprp_pkg::STR_W-1:0]    str_dec;
  logic                          had;
  logic                          user;
  lprp_pkg::kind_t               skind;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && q_ready;
  assign b           = in_ch.data_byte;
  assign word        = {shift_r, b};
  assign word_done   = (cnt_r == 2'd3);
  assign rem_dec     = frame_rem_r - 1'b1;
  assign str_dec     = str_rem_r - 1'b1;
  assign had         = had_zero_r | (b == 8'd0);
  assign user        = (phase_r == PH_UBYTES);
  assign skind       = user ? lprp_pkg::KIND_USER : lprp_pkg::KIND_MSG;
  assign sticky_err  = sticky_r;

  always_comb begin
    frame_on_nxt  = frame_on_r;
    frame_rem_nxt = frame_rem_r;
    shift_nxt     = shift_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    str_rem_nxt   = str_rem_r;
    had_zero_nxt  = had_zero_r;
    sticky_nxt    = sticky_r;
    push_valid    = 1'b0;
    push_data     = '{kind: lprp_pkg::KIND_HOST, value: 32'd0, string_end: 1'b0};

    if (accept && !sticky_r) begin
      if (!frame_on_r) begin
        if (word_done) begin
          shift_nxt = '0;
          cnt_nxt   = 2'd0;
          if (word[31]) begin
            sticky_nxt = 1'b1;
            push_valid = 1'b1;
            push_data  = '{kind: lprp_pkg::KIND_ERROR, value: lprp_pkg::ERR_NEG_FRAME,
                           string_end: 1'b0};
          end else if (word == 32'd0) begin
          end else if (word > 32'(lprp_pkg::MAX_FRAME_BYTES)) begin
            sticky_nxt = 1'b1;
            push_valid = 1'b1;
            push_data  = '{kind: lprp_pkg::KIND_ERROR, value: lprp_pkg::ERR_BIG_FRAME,
                           string_end: 1'b0};
          end else begin
            frame_on_nxt  = 1'b1;
            frame_rem_nxt = word[lprp_pkg::FRAME_W-1:0];
            phase_nxt     = PH_START;
            str_rem_nxt   = '0;
            had_zero_nxt  = 1'b0;
          end
        end else begin
          shift_nxt = {shift_r[15:0], b};
          cnt_nxt   = cnt_r + 2'd1;
        end
      end else begin
        frame_rem_nxt = rem_dec;
        unique case (phase_r) inside
          PH_START, PH_HOST, PH_ULEN, PH_CMD, PH_MLEN, PH_END: begin
            if (word_done) begin
              shift_nxt = '0;
              cnt_nxt   = 2'd0;
              unique case (phase_r) inside
                PH_START: begin
                  if (word == cfg.start_marker) phase_nxt = PH_HOST;
                end
                PH_HOST: begin
                  push_valid = 1'b1;
                  push_data  = '{kind: lprp_pkg::KIND_HOST, value: word, string_end: 1'b0};
                  phase_nxt  = PH_ULEN;
                end
                PH_CMD: begin
                  push_valid = 1'b1;
                  push_data  = '{kind: lprp_pkg::KIND_CMD, value: word, string_end: 1'b0};
                  phase_nxt  = PH_MLEN;
                end
                PH_END: begin
                  if (word == cfg.end_marker) begin
                    push_valid = 1'b1;
                    push_data  = '{kind: lprp_pkg::KIND_DONE, value: word, string_end: 1'b0};
                    phase_nxt  = PH_START;
                  end
                end
                default: begin
                  if (word > {15'd0, cfg.string_limit}) begin
                    push_valid = 1'b1;
                    push_data  = '{kind: lprp_pkg::KIND_ERROR,
                                   value: lprp_pkg::ERR_BIG_STRING, string_end: 1'b0};
                    phase_nxt  = PH_DISCARD;
                  end else if (word == 32'd0) begin
                    phase_nxt = (phase_r == PH_ULEN) ? PH_CMD : PH_END;
                  end else begin
                    str_rem_nxt  = word[lprp_pkg::STR_W-1:0];
                    had_zero_nxt = 1'b0;
                    phase_nxt    = (phase_r == PH_ULEN) ? PH_UBYTES : PH_MBYTES;
                  end
                end
              endcase
            end else begin
              shift_nxt = {shift_r[15:0], b};
              cnt_nxt   = cnt_r + 2'd1;
            end
          end
          PH_UBYTES, PH_MBYTES: begin
            str_rem_nxt = str_dec;
            push_valid  = 1'b1;
            if (str_dec == '0) begin
              had_zero_nxt = 1'b0;
              if (had) begin
                push_data = '{kind: lprp_pkg::KIND_REJECT, value: {29'd0, skind},
                              string_end: 1'b0};
                phase_nxt = user ? PH_ULEN : PH_MLEN;
              end else begin
                push_data = '{kind: skind, value: {24'd0, b}, string_end: 1'b1};
                phase_nxt = user ? PH_CMD : PH_END;
              end
            end else begin
              had_zero_nxt = had;
              push_data    = '{kind: skind, value: {24'd0, b}, string_end: 1'b0};
            end
          end
          default: begin
          end
        endcase

        if (rem_dec == '0) begin
          if ((is_word_phase(phase_nxt) && (cnt_nxt != 2'd0)) || is_str_phase(phase_nxt)) begin
            push_valid = 1'b1;
            push_data  = '{kind: lprp_pkg::KIND_ERROR, value: lprp_pkg::ERR_TRUNCATED,
                           string_end: 1'b0};
          end
          frame_on_nxt = 1'b0;
          shift_nxt    = '0;
          cnt_nxt      = 2'd0;
          phase_nxt    = PH_START;
          str_rem_nxt  = '0;
          had_zero_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_on_r  <= 1'b0;
      frame_rem_r <= '0;
      shift_r     <= '0;
      cnt_r       <= 2'd0;
      phase_r     <= PH_START;
      str_rem_r   <= '0;
      had_zero_r  <= 1'b0;
      sticky_r    <= 1'b0;
    end else begin
      frame_on_r  <= frame_on_nxt;
      frame_rem_r <= frame_rem_nxt;
      shift_r     <= shift_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      str_rem_r   <= str_rem_nxt;
      had_zero_r  <= had_zero_nxt;
      sticky_r    <= sticky_nxt;
    end
  end

endmodule

/* design/lprp_queue.sv */
// Back end: two-entry result queue whose head register drives the result channel.
// Depends on lprp_pkg and lprp_out_if.
module lprp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  lprp_pkg::result_t push_data,
  output logic              push_ready,
  lprp_out_if.source        out_ch
);

  logic              head_v_r, head_v_nxt;
  logic              tail_v_r, tail_v_nxt;
  lprp_pkg::result_t head_r,   head_nxt;
  lprp_pkg::result_t tail_r,   tail_nxt;
  logic              pop;

  assign push_ready        = !tail_v_r;
  assign pop               = head_v_r && out_ch.ready;
  assign out_ch.valid      = head_v_r;
  assign out_ch.kind       = head_r.kind;
  assign out_ch.value      = head_r.value;
  assign out_ch.string_end = head_r.string_end;

  always_comb begin
    head_v_nxt = head_v_r;
    tail_v_nxt = tail_v_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    if (pop) begin
      if (tail_v_r) begin
        head_nxt   = tail_r;
        tail_v_nxt = 1'b0;
      end else if (push_valid) begin
        head_nxt = push_data;
      end else begin
        head_v_nxt = 1'b0;
      end
    end else if (push_valid && !tail_v_r) begin
      if (!head_v_r) begin
        head_nxt   = push_data;
        head_v_nxt = 1'b1;
      end else begin
        tail_nxt   = push_data;
        tail_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      tail_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      tail_v_r <= tail_v_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule
